/* rtl/mswm_pkg.sv */
package mswm_pkg;

    localparam int SPEED_WIDTH     = 20;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_N          = 1 << SINE_TABLE_BITS;
    localparam int CMD_W           = 20;
    localparam int WHEEL_W         = 24;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int SIN_W           = 16;
    localparam int PROD_W          = 48;

    localparam logic [CFG_IDX_W-1:0] REG_RISE_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_TURN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_TURN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY  = 3'd6;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_GYRO   = 2'd1;

    typedef logic signed [SPEED_WIDTH-1:0] t_speed;

    typedef struct packed {
        logic signed [CMD_W-1:0] cmd_x;
        logic signed [CMD_W-1:0] cmd_y;
        logic signed [CMD_W-1:0] cmd_turn;
        logic [8:0]              speed_scale;
        logic [1:0]              drive_mode;
        logic [15:0]             gimbal_yaw;
    } t_in_item;

    typedef struct packed {
        logic signed [WHEEL_W-1:0] wheel_front_right;
        logic signed [WHEEL_W-1:0] wheel_front_left;
        logic signed [WHEEL_W-1:0] wheel_rear_left;
        logic signed [WHEEL_W-1:0] wheel_rear_right;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_item;

    // Round a signed value shifted right by n, half away from zero.
    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] v, input int n);
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] r;
        begin
            m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
            r = (m + (PROD_W'(1) << (n - 1))) >> n;
            return v[PROD_W-1] ? -$signed(r) : $signed(r);
        end
    endfunction

    function automatic logic signed [PROD_W-1:0] sat_w(
        input logic signed [PROD_W-1:0] v, input int w);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        begin
            hi = (PROD_W'(1) <<< (w - 1)) - PROD_W'(1);
            lo = -hi - PROD_W'(1);
            return (v > hi) ? hi : ((v < lo) ? lo : v);
        end
    endfunction

    // Quarter-wave polynomial, evaluated at elaboration for the constant table.
    function automatic logic [SIN_W-1:0] quarter_sine(input longint unsigned u);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned y;
        begin
            x  = u << (30 - (SINE_TABLE_BITS - 2));
            x2 = (x * x) >> 30;
            t  = 64'd172272;
            t  = 64'd5026995   - ((t * x2) >> 30);
            t  = 64'd85569306  - ((t * x2) >> 30);
            t  = 64'd693598668 - ((t * x2) >> 30);
            t  = 64'd1686629713 - ((t * x2) >> 30);
            y  = (t * x) >> 30;
            y  = (y + 64'd32768) >> 16;
            if (y > 64'd16384) y = 64'd16384;
            return SIN_W'(y);
        end
    endfunction

    function automatic logic [SINE_N/4-1:0][SIN_W-1:0] build_qsine();
        logic [SINE_N/4-1:0][SIN_W-1:0] tbl;
        begin
            for (int u = 0; u < SINE_N / 4; u++) tbl[u] = quarter_sine(64'(u));
            return tbl;
        end
    endfunction

    // First quarter of the wave, plus the peak at a quarter turn.
    localparam logic [SINE_N/4-1:0][SIN_W-1:0] QSINE = build_qsine();
    localparam logic [SIN_W-1:0] SINE_PEAK = quarter_sine(64'(SINE_N / 4));

    // Full-turn sine from the quarter table: mirror odd quadrants, negate the lower half.
    function automatic logic signed [SIN_W-1:0] sine_lookup(
        input logic [SINE_TABLE_BITS-1:0] k);
        logic [SINE_TABLE_BITS-3:0] r;
        logic [SINE_TABLE_BITS-3:0] ri;
        logic [SIN_W-1:0] s;
        begin
            r  = k[SINE_TABLE_BITS-3:0];
            ri = -r;
            if (!k[SINE_TABLE_BITS-2]) s = QSINE[r];
            else if (r == '0) s = SINE_PEAK;
            else s = QSINE[ri];
            return k[SINE_TABLE_BITS-1] ? -$signed(s) : $signed(s);
        end
    endfunction

endpackage

/* rtl/mswm_if.sv */
interface mswm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/mswm_alu.sv */
module mswm_alu (
    input  logic                            i_clk,
    input  logic signed [mswm_pkg::CMD_W:0] i_a,
    input  logic signed [17:0]              i_b,
    output logic signed [mswm_pkg::PROD_W-1:0] o_p
);
    import mswm_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    // Single shared multiplier, product registered.
    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a * i_b);
    end

    assign o_p = r_p;
endmodule

/* rtl/mswm_slew.sv */
module mswm_slew (
    input  logic signed [mswm_pkg::SPEED_WIDTH-1:0] i_cmd,
    input  logic signed [mswm_pkg::SPEED_WIDTH-1:0] i_plan,
    input  logic [15:0]                             i_rise,
    input  logic [15:0]                             i_fall,
    output logic signed [mswm_pkg::SPEED_WIDTH-1:0] o_plan
);
    import mswm_pkg::*;

    localparam int W = SPEED_WIDTH + 2;

    logic signed [W-1:0] c, q, mc, mq, d, md, rise, fall, res;
    logic same;

    always_comb begin
        c    = W'(i_cmd);
        q    = W'(i_plan);
        rise = W'($signed({1'b0, i_rise}));
        fall = W'($signed({1'b0, i_fall}));
        mc   = c[W-1] ? -c : c;
        mq   = q[W-1] ? -q : q;
        d    = mc - mq;
        md   = d[W-1] ? -d : d;
        same = (c != '0) && !((c > 0 && q < 0) || (c < 0 && q > 0));
        if (same) begin
            if (md <= rise) res = c;
            else if ((d > 0) == (c > 0)) res = q + rise;
            else res = q - rise;
        end else begin
            if (mq < fall) res = '0;
            else if (q > 0) res = q - fall;
            else res = q + fall;
        end
        o_plan = SPEED_WIDTH'(res);
    end
endmodule

/* rtl/mecanum_slew_limited_wheel_mixer.sv */
// Mecanum wheel mixer with per-axis slew limiting.
// Channels: i_cmd (sink) takes one transaction per control tick holding the
// x, y, turn commands, speed scale, drive mode and gimbal yaw. o_wheel
// (source) gives the four saturated wheel speed targets. i_cfg (sink) writes
// the seven step/geometry registers by index; indexes beyond six are dropped.
// Sequence: after acceptance a normal or gyro tick passes the MX, MY, MT, SLEW,
// R0-R3, RW and MIX states and raises o_wheel.valid from OUT; one shared
// 21x18 multiplier performs the three scalings, the four rotation products and
// the turn-geometry product in turn, and a new tick is accepted only after the
// last result enters the output register. Hold mode (and the unused code)
// consumes the transaction, gives no result and leaves the planned speeds
// untouched. Reset clears the planned speeds, reloads register defaults and
// empties the output register. While the receiver stalls the result is held
// in the output register; the next tick is still accepted and worked on,
// waiting only at the hand-off until the register is free.
module mecanum_slew_limited_wheel_mixer (
    input  logic i_clk,
    input  logic i_rst_n,
    mswm_stream_if.sink   i_cmd,
    mswm_stream_if.sink   i_cfg,
    mswm_stream_if.source o_wheel
);
    import mswm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MX, S_MY, S_MT, S_SLEW, S_R0, S_R1, S_R2, S_R3, S_RW,
        S_W, S_MIX, S_OUT
    } t_state;

    t_state r_state;
    t_in_item r_in;
    logic [15:0] r_rise_x, r_rise_y, r_rise_t, r_fall_x, r_fall_y, r_fall_t, r_geom;
    t_speed r_px, r_py, r_pt;
    t_speed r_sx, r_sy, r_st;
    logic signed [PROD_W-1:0] r_acc0, r_acc1, r_w;
    logic signed [SIN_W-1:0] r_sin, r_cos;
    t_out_item r_out;
    logic r_out_valid;

    logic signed [CMD_W:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    t_speed n_px, n_py, n_pt;
    t_speed scaled_p;
    logic [SINE_TABLE_BITS-1:0] k;
    logic signed [PROD_W-1:0] vx, vy, w;

    mswm_alu u_alu (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));

    mswm_slew u_sx (.i_cmd(r_sx), .i_plan(r_px), .i_rise(r_rise_x),
                    .i_fall(r_fall_x), .o_plan(n_px));
    mswm_slew u_sy (.i_cmd(r_sy), .i_plan(r_py), .i_rise(r_rise_y),
                    .i_fall(r_fall_y), .o_plan(n_py));
    mswm_slew u_st (.i_cmd(r_st), .i_plan(r_pt), .i_rise(r_rise_t),
                    .i_fall(r_fall_t), .o_plan(n_pt));

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_wheel.valid = r_out_valid;
    assign o_wheel.data  = r_out;

    assign k = SINE_TABLE_BITS'((17'h10000 - 17'(r_in.gimbal_yaw)) >> (16 - SINE_TABLE_BITS));
    assign scaled_p = SPEED_WIDTH'(sat_w(rnd_shift(mul_p, 8), SPEED_WIDTH));

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_IDLE: begin
                mul_a = (CMD_W+1)'(i_cmd.data.cmd_x);
                mul_b = 18'($signed({1'b0, i_cmd.data.speed_scale}));
            end
            S_MX: begin
                mul_a = (CMD_W+1)'(r_in.cmd_y);
                mul_b = 18'($signed({1'b0, r_in.speed_scale}));
            end
            S_MY: begin
                mul_a = (CMD_W+1)'(r_in.cmd_turn);
                mul_b = 18'($signed({1'b0, r_in.speed_scale}));
            end
            S_SLEW: begin
                mul_a = -(CMD_W+1)'(n_px);
                mul_b = 18'(sine_lookup(k + SINE_TABLE_BITS'(SINE_N / 4)));
            end
            S_R0: begin
                mul_a = (CMD_W+1)'(r_py);
                mul_b = 18'(r_sin);
            end
            S_R1: begin
                mul_a = (CMD_W+1)'(r_px);
                mul_b = 18'(r_sin);
            end
            S_R2: begin
                mul_a = (CMD_W+1)'(r_py);
                mul_b = 18'(r_cos);
            end
            S_R3: begin
                mul_a = (CMD_W+1)'(r_pt);
                mul_b = 18'($signed({2'b0, r_geom}));
            end
            default: ;
        endcase
    end

    always_comb begin
        if (r_in.drive_mode == MODE_GYRO) begin
            vx = rnd_shift(r_acc0, 14);
            vy = rnd_shift(r_acc1, 14);
        end else begin
            vx = -PROD_W'(r_px);
            vy = PROD_W'(r_py);
        end
        w = r_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_px <= '0; r_py <= '0; r_pt <= '0;
            r_rise_x <= 16'd61;  r_rise_y <= 16'd61;  r_rise_t <= 16'd92;
            r_fall_x <= 16'd154; r_fall_y <= 16'd154; r_fall_t <= 16'd154;
            r_geom   <= 16'd256;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.data.index)
                    REG_RISE_X:    r_rise_x <= i_cfg.data.data;
                    REG_RISE_Y:    r_rise_y <= i_cfg.data.data;
                    REG_RISE_TURN: r_rise_t <= i_cfg.data.data;
                    REG_FALL_X:    r_fall_x <= i_cfg.data.data;
                    REG_FALL_Y:    r_fall_y <= i_cfg.data.data;
                    REG_FALL_TURN: r_fall_t <= i_cfg.data.data;
                    REG_GEOMETRY:  r_geom   <= i_cfg.data.data;
                    default: ;
                endcase
            end
            if (o_wheel.valid && o_wheel.ready && r_state != S_OUT) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_cmd.valid) begin
                    r_in    <= i_cmd.data;
                    r_state <= (i_cmd.data.drive_mode == MODE_NORMAL ||
                                i_cmd.data.drive_mode == MODE_GYRO) ? S_MX : S_W;
                end
                S_MX: begin r_sx <= scaled_p; r_state <= S_MY; end
                S_MY: begin r_sy <= scaled_p; r_state <= S_MT; end
                S_MT: begin r_st <= scaled_p; r_state <= S_SLEW; end
                S_SLEW: begin
                    // Advance all three planned speeds at once.
                    r_px  <= n_px; r_py <= n_py; r_pt <= n_pt;
                    r_sin <= sine_lookup(k);
                    r_cos <= sine_lookup(k + SINE_TABLE_BITS'(SINE_N / 4));
                    r_state <= S_R0;
                end
                S_R0: begin r_acc0 <= mul_p; r_state <= S_R1; end
                S_R1: begin r_acc0 <= r_acc0 + mul_p; r_state <= S_R2; end
                S_R2: begin r_acc1 <= mul_p; r_state <= S_R3; end
                S_R3: begin r_acc1 <= r_acc1 + mul_p; r_state <= S_RW; end
                S_RW: begin r_w <= rnd_shift(mul_p, 8); r_state <= S_MIX; end
                S_MIX: r_state <= S_OUT;
                S_OUT: if (!r_out_valid || o_wheel.ready) begin
                    r_out.wheel_front_right <= WHEEL_W'(sat_w(vy - vx + w, WHEEL_W));
                    r_out.wheel_front_left  <= WHEEL_W'(sat_w(vx + vy + w, WHEEL_W));
                    r_out.wheel_rear_left   <= WHEEL_W'(sat_w(vx - vy + w, WHEEL_W));
                    r_out.wheel_rear_right  <= WHEEL_W'(sat_w(w - vx - vy, WHEEL_W));
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_W: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ready |-> r_state == S_IDLE)) else $error("ready outside idle");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wheel.valid && !o_wheel.ready |=> o_wheel.valid && $stable(o_wheel.data)))
        else $error("result lost under stall");
    a_plan_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SLEW |=> $stable(r_px) && $stable(r_pt)))
        else $error("plan changed outside update");
    a_hold_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W |=> r_state == S_IDLE)) else $error("hold stuck");
`endif
endmodule

/* test/mswm_checker.sv */
`timescale 1ns / 100ps

module mswm_checker
    import mswm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  logic      i_cmd_ready,
    input  t_in_item  i_cmd_data,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  t_cfg_item i_cfg_data,
    input  logic      i_wheel_valid,
    input  logic      i_wheel_ready,
    input  t_out_item i_wheel_data,
    output int        o_mismatches,
    output int        o_pending,
    output int        o_results
);

    localparam int QUARTER = SINE_N / 4;

    longint    plan_x, plan_y, plan_turn;
    longint    rise_x, rise_y, rise_turn;
    longint    fall_x, fall_y, fall_turn;
    longint    geometry;
    longint    sine_lut [SINE_N];
    t_out_item wheel_fifo [$];

    // Half away from zero.
    function automatic longint round_shr(longint v, int n);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (n - 1))) >>> n;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
    endfunction

    function automatic longint wave_quarter(longint unsigned u);
        longint unsigned x, x2, t, y;
        x  = u << (30 - (SINE_TABLE_BITS - 2));
        x2 = (x * x) >> 30;
        t  = 172272;
        t  = 5026995 - ((t * x2) >> 30);
        t  = 85569306 - ((t * x2) >> 30);
        t  = 693598668 - ((t * x2) >> 30);
        t  = 1686629713 - ((t * x2) >> 30);
        y  = (t * x) >> 30;
        y  = (y + 32768) >> 16;
        if (y > 16384) y = 16384;
        return longint'(y);
    endfunction

    function automatic longint slew_axis(longint c, longint p, longint rise, longint fall);
        longint d;
        longint mc, mp;
        mc = (c < 0) ? -c : c;
        mp = (p < 0) ? -p : p;
        if (c != 0 && !((c > 0 && p < 0) || (c < 0 && p > 0))) begin
            d = mc - mp;
            if (((d < 0) ? -d : d) <= rise) return c;
            if (d > 0) return p + ((c > 0) ? rise : -rise);
            return p - ((c > 0) ? rise : -rise);
        end
        if (mp < fall) return 0;
        return p + ((p > 0) ? -fall : fall);
    endfunction

    function automatic longint scale_cmd(logic signed [CMD_W-1:0] c, logic [8:0] s);
        return clamp(round_shr(longint'(c) * longint'(s), 8), SPEED_WIDTH);
    endfunction

    // Advance the planned speeds and mix them into four wheel targets.
    task automatic mix_wheels(input t_in_item it);
        longint    vx, vy, w, sn, cs;
        longint    wh [4];
        int        k;
        logic [15:0] ang;
        t_out_item r;
        plan_x    = slew_axis(scale_cmd(it.cmd_x, it.speed_scale), plan_x, rise_x, fall_x);
        plan_y    = slew_axis(scale_cmd(it.cmd_y, it.speed_scale), plan_y, rise_y, fall_y);
        plan_turn = slew_axis(scale_cmd(it.cmd_turn, it.speed_scale), plan_turn,
                              rise_turn, fall_turn);
        if (it.drive_mode == MODE_GYRO) begin
            ang = 16'd0 - it.gimbal_yaw;
            k   = int'(ang >> (16 - SINE_TABLE_BITS));
            sn  = sine_lut[k];
            cs  = sine_lut[(k + QUARTER) % SINE_N];
            vx  = round_shr(-plan_x * cs + plan_y * sn, 14);
            vy  = round_shr(plan_x * sn + plan_y * cs, 14);
        end else begin
            vx = -plan_x;
            vy = plan_y;
        end
        w = round_shr(plan_turn * geometry, 8);
        wh[0] = vy - vx + w;
        wh[1] = vx + vy + w;
        wh[2] = vx - vy + w;
        wh[3] = w - vx - vy;
        r.wheel_front_right = WHEEL_W'(clamp(wh[0], WHEEL_W));
        r.wheel_front_left  = WHEEL_W'(clamp(wh[1], WHEEL_W));
        r.wheel_rear_left   = WHEEL_W'(clamp(wh[2], WHEEL_W));
        r.wheel_rear_right  = WHEEL_W'(clamp(wh[3], WHEEL_W));
        wheel_fifo.push_back(r);
    endtask

    initial begin
        int q, r;
        for (int k = 0; k < SINE_N; k++) begin
            q = k / QUARTER;
            r = k % QUARTER;
            sine_lut[k] = (q % 2) ? wave_quarter(QUARTER - r) : wave_quarter(r);
            if (q >= 2) sine_lut[k] = -sine_lut[k];
        end
        o_mismatches = 0;
        o_results    = 0;
    end

    assign o_pending = wheel_fifo.size();

    always @(posedge i_clk) begin
        t_out_item  want;
        string      names [4];
        logic [WHEEL_W-1:0] a, e;
        names = '{"front_right", "front_left", "rear_left", "rear_right"};
        if (!i_rst_n) begin
            plan_x = 0; plan_y = 0; plan_turn = 0;
            rise_x = 61; rise_y = 61; rise_turn = 92;
            fall_x = 154; fall_y = 154; fall_turn = 154;
            geometry = 256;
            wheel_fifo.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    REG_RISE_X:    rise_x    = i_cfg_data.data;
                    REG_RISE_Y:    rise_y    = i_cfg_data.data;
                    REG_RISE_TURN: rise_turn = i_cfg_data.data;
                    REG_FALL_X:    fall_x    = i_cfg_data.data;
                    REG_FALL_Y:    fall_y    = i_cfg_data.data;
                    REG_FALL_TURN: fall_turn = i_cfg_data.data;
                    REG_GEOMETRY:  geometry  = i_cfg_data.data;
                    default: ;
                endcase
            end
            if (i_cmd_valid && i_cmd_ready &&
                (i_cmd_data.drive_mode == MODE_NORMAL || i_cmd_data.drive_mode == MODE_GYRO))
                mix_wheels(i_cmd_data);
            if (i_wheel_valid && i_wheel_ready) begin
                o_results++;
                if (wheel_fifo.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("unexpected wheel transaction %h", i_wheel_data);
                end else begin
                    want = wheel_fifo.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        e = want[WHEEL_W*(3-i) +: WHEEL_W];
                        a = i_wheel_data[WHEEL_W*(3-i) +: WHEEL_W];
                        if (a !== e) begin
                            o_mismatches++;
                            if (o_mismatches <= 10)
                                $display("wheel %s: expected %0d, got %0d", names[i],
                                         $signed(e), $signed(a));
                        end
                    end
                end
            end
        end
    end

endmodule

/* test/mecanum_slew_limited_wheel_mixer_test.sv */
`timescale 1ns / 100ps

module mecanum_slew_limited_wheel_mixer_test;
    import mswm_pkg::*;

    // Codes that consume a transaction without producing a result.
    localparam logic [1:0] MODE_HOLD  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 240;

    logic i_clk;
    logic i_rst_n;
    logic no_idle;
    int   cycles;
    int   mismatches, pending, results;
    int   ticks_sent;

    mswm_stream_if #(.T(t_in_item))  cmd_if ();
    mswm_stream_if #(.T(t_cfg_item)) cfg_if ();
    mswm_stream_if #(.T(t_out_item)) wheel_if ();

    mecanum_slew_limited_wheel_mixer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .i_cfg   (cfg_if.sink),
        .o_wheel (wheel_if.source)
    );

    mswm_checker wheel_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_if.valid),
        .i_cmd_ready   (cmd_if.ready),
        .i_cmd_data    (cmd_if.data),
        .i_cfg_valid   (cfg_if.valid),
        .i_cfg_ready   (cfg_if.ready),
        .i_cfg_data    (cfg_if.data),
        .i_wheel_valid (wheel_if.valid),
        .i_wheel_ready (wheel_if.ready),
        .i_wheel_data  (wheel_if.data),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_results     (results)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Stall the receiver now and then, except during the quiet stretch.
    always @(posedge i_clk)
        wheel_if.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 9);

    // Watchdog: fail and end the run once the cycle count passes CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL mecanum_slew_limited_wheel_mixer");
            $finish;
        end
    end

    // Present one command transaction, idling first at random, and hold it until taken.
    task automatic send_tick(input t_in_item it);
        logic rdy;
        while (!no_idle && $urandom_range(99) < 9) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= it;
        do begin
            @(negedge i_clk);
            rdy = cmd_if.ready;
            @(posedge i_clk);
        end while (!rdy);
        if (it.drive_mode == MODE_NORMAL || it.drive_mode == MODE_GYRO) ticks_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        logic rdy;
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, data: val};
        do begin
            @(negedge i_clk);
            rdy = cfg_if.ready;
            @(posedge i_clk);
        end while (!rdy);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain: wait for every result, then cover a trailing hold transaction.
    task automatic drain();
        cmd_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic load_steps(input logic [15:0] rx, ry, rt, fx, fy, ft, geo);
        drain();
        write_reg(REG_RISE_X, rx);
        write_reg(REG_RISE_Y, ry);
        write_reg(REG_RISE_TURN, rt);
        write_reg(REG_FALL_X, fx);
        write_reg(REG_FALL_Y, fy);
        write_reg(REG_FALL_TURN, ft);
        write_reg(REG_GEOMETRY, geo);
        write_reg(REG_UNUSED, 16'($urandom));
    endtask

    function automatic logic signed [CMD_W-1:0] pick_speed();
        case ($urandom_range(9))
            0:       return 20'sh7FFFF;
            1:       return 20'sh80000;
            2:       return '0;
            3, 4, 5: return CMD_W'($signed($urandom_range(4000)) - 2000);
            default: return CMD_W'($urandom);
        endcase
    endfunction

    function automatic logic [8:0] pick_scale();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return 9'($urandom_range(511, 257));
        if (r < 18) return 9'd256;
        return 9'($urandom_range(256));
    endfunction

    function automatic logic [1:0] pick_mode(input int hold_pct);
        int r;
        r = $urandom_range(99);
        if (r < hold_pct / 2) return MODE_HOLD;
        if (r < hold_pct)     return MODE_SPARE;
        return r[0] ? MODE_GYRO : MODE_NORMAL;
    endfunction

    function automatic t_in_item make_tick(input logic signed [CMD_W-1:0] x, y, t,
                                           input logic [8:0] s, input logic [1:0] m,
                                           input logic [15:0] yaw);
        t_in_item it;
        it.cmd_x = x; it.cmd_y = y; it.cmd_turn = t;
        it.speed_scale = s; it.drive_mode = m; it.gimbal_yaw = yaw;
        return it;
    endfunction

    // Mostly runs of a held command so the planners ramp, with occasional x
    // reversals; the rest single noise ticks.
    task automatic random_phase();
        t_in_item it;
        int       stop, run;
        stop = ticks_sent + PHASE_ITEMS;
        while (ticks_sent < stop) begin
            if ($urandom_range(99) < 15) begin
                send_tick(make_tick(CMD_W'($urandom), CMD_W'($urandom), CMD_W'($urandom),
                                    9'($urandom), 2'($urandom), 16'($urandom)));
            end else begin
                it  = make_tick(pick_speed(), pick_speed(), pick_speed(), pick_scale(),
                                MODE_NORMAL, 16'($urandom));
                run = $urandom_range(24, 1);
                for (int i = 0; i < run; i++) begin
                    it.drive_mode = pick_mode(8);
                    it.gimbal_yaw = it.gimbal_yaw + 16'($urandom_range(2048));
                    if ($urandom_range(99) < 5) it.cmd_x = -it.cmd_x;
                    send_tick(it);
                end
            end
        end
    endtask

    initial begin
        logic [15:0] yaw_list [6];
        yaw_list = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535, 16'd100};
        no_idle        = 1'b0;
        cycles         = 0;
        ticks_sent     = 0;
        i_rst_n        = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.data    = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;
        wheel_if.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every mode, reversals and saturation at default steps.
        send_tick(make_tick('0, '0, '0, 9'd256, MODE_NORMAL, 16'd0));
        send_tick(make_tick(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 9'd256, MODE_NORMAL, 16'd0));
        send_tick(make_tick(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 9'd511, MODE_NORMAL, 16'd0));
        send_tick(make_tick(20'sh80000, 20'sh80000, 20'sh80000, 9'd256, MODE_NORMAL, 16'd0));
        send_tick(make_tick(20'sh80000, 20'sh80000, 20'sh80000, 9'd511, MODE_HOLD, 16'd0));
        send_tick(make_tick(20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 9'd511, MODE_SPARE, 16'hFFFF));
        send_tick(make_tick(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 9'd0, MODE_NORMAL, 16'd0));
        for (int i = 0; i < 6; i++)
            send_tick(make_tick(20'sd900, -20'sd700, 20'sd300, 9'd256, MODE_GYRO,
                                yaw_list[i]));
        send_tick(make_tick(-20'sd900, 20'sd700, -20'sd300, 9'd256, MODE_GYRO, 16'd8192));
        send_tick(make_tick(20'sd40, 20'sd40, 20'sd40, 9'd256, MODE_NORMAL, 16'd0));
        send_tick(make_tick('0, '0, '0, 9'd256, MODE_NORMAL, 16'd0));

        // Large steps and geometry drive the wheel sums into saturation.
        load_steps(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tick(make_tick(20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 9'd256, MODE_NORMAL, 16'd0));
        send_tick(make_tick(20'sh80000, 20'sh7FFFF, 20'sh80000, 9'd511, MODE_GYRO, 16'd4096));
        send_tick(make_tick(20'sh80000, 20'sh7FFFF, 20'sh80000, 9'd511, MODE_GYRO, 16'd40000));
        random_phase();

        // Zero steps freeze the plans.
        load_steps('0, '0, '0, '0, '0, '0, '0);
        random_phase();

        load_steps(16'd61, 16'd61, 16'd92, 16'd154, 16'd154, 16'd154, 16'd256);
        random_phase();

        // Quiet stretch: neither side idles.
        load_steps(16'($urandom_range(400, 1)), 16'($urandom_range(400, 1)),
                   16'($urandom_range(400, 1)), 16'($urandom_range(400, 1)),
                   16'($urandom_range(400, 1)), 16'($urandom_range(400, 1)),
                   16'($urandom));
        no_idle = 1'b1;
        random_phase();
        no_idle = 1'b0;

        load_steps(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
        random_phase();

        // Slow rise, fast fall.
        load_steps(16'd3, 16'd5, 16'd7, 16'd2000, 16'd3000, 16'd4000, 16'd700);
        random_phase();

        drain();
        $display("Sent %0d mixing ticks over seven register settings; %0d wheel results seen.",
                 ticks_sent, results);
        if (mismatches == 0 && pending == 0)
            $display("PASS mecanum_slew_limited_wheel_mixer");
        else
            $display("FAIL mecanum_slew_limited_wheel_mixer");
        $finish;
    end

endmodule
